// ===== design/pob_pkg.sv =====
`timescale 1ns / 1ps

package pob_pkg;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int REG_W      = 13;
  localparam int POS_W      = 14;
  localparam int IDX_W      = 24;
  localparam int PROD_W     = 2 * REG_W;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 2;

  // rounding bias ahead of the divide by 255
  localparam logic [2*BYTE_W-1:0] ROUND_BIAS = 16'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 2'd0,
    CFG_OFFSET_Y    = 2'd1,
    CFG_DEST_WIDTH  = 2'd2,
    CFG_DEST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef logic [LANES-1:0][BYTE_W-1:0] pix_t;

  // per-stage load enables, driven by the pipeline control in the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pob_adv_t;

endpackage

// ===== design/pob_in_if.sv =====
`timescale 1ns / 1ps

interface pob_in_if;
  logic                            valid;
  logic                            ready;
  logic [pob_pkg::COORD_W-1:0]     ovl_col;
  logic [pob_pkg::COORD_W-1:0]     ovl_row;
  logic [pob_pkg::BYTE_W-1:0]      src_c0;
  logic [pob_pkg::BYTE_W-1:0]      src_c1;
  logic [pob_pkg::BYTE_W-1:0]      src_c2;
  logic [pob_pkg::BYTE_W-1:0]      src_alpha;
  logic [pob_pkg::BYTE_W-1:0]      bg_c0;
  logic [pob_pkg::BYTE_W-1:0]      bg_c1;
  logic [pob_pkg::BYTE_W-1:0]      bg_c2;
  logic [pob_pkg::BYTE_W-1:0]      bg_alpha;

  modport source (output valid, ovl_col, ovl_row, src_c0, src_c1, src_c2, src_alpha,
                  bg_c0, bg_c1, bg_c2, bg_alpha, input ready);
  modport sink (input valid, ovl_col, ovl_row, src_c0, src_c1, src_c2, src_alpha,
                bg_c0, bg_c1, bg_c2, bg_alpha, output ready);
endinterface

// ===== design/pob_out_if.sv =====
`timescale 1ns / 1ps

interface pob_out_if;
  logic                        valid;
  logic                        ready;
  logic [pob_pkg::BYTE_W-1:0]  out_c0;
  logic [pob_pkg::BYTE_W-1:0]  out_c1;
  logic [pob_pkg::BYTE_W-1:0]  out_c2;
  logic [pob_pkg::BYTE_W-1:0]  out_alpha;
  logic                        write_enable;
  logic [pob_pkg::IDX_W-1:0]   dest_index;

  modport source (output valid, out_c0, out_c1, out_c2, out_alpha, write_enable,
                  dest_index, input ready);
  modport sink (input valid, out_c0, out_c1, out_c2, out_alpha, write_enable,
                dest_index, output ready);
endinterface

// ===== design/pob_cfg_if.sv =====
`timescale 1ns / 1ps

interface pob_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pob_pkg::CFG_IDX_W-1:0]   index;
  logic [pob_pkg::REG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pob_geom.sv =====
`timescale 1ns / 1ps

module pob_geom #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  pob_pkg::pob_adv_t             adv,
  input  logic [pob_pkg::REG_W-1:0]     offset_x,
  input  logic [pob_pkg::REG_W-1:0]     offset_y,
  input  logic [pob_pkg::REG_W-1:0]     dest_width,
  input  logic [pob_pkg::REG_W-1:0]     dest_height,
  input  logic [pob_pkg::COORD_W-1:0]   ovl_col,
  input  logic [pob_pkg::COORD_W-1:0]   ovl_row,
  output logic                          inside_s2,
  output logic [pob_pkg::IDX_W-1:0]     dest_index
);

  localparam int PAD_W = 32 - pob_pkg::REG_W;
  localparam int EXT_W = pob_pkg::POS_W - pob_pkg::COORD_W;

  logic [pob_pkg::POS_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic [pob_pkg::REG_W-1:0]  w_r, h_r, w_nxt, h_nxt;
  logic                       inside_r, inside_nxt;
  logic [pob_pkg::IDX_W-1:0]  prod_r;
  logic [pob_pkg::PROD_W-1:0] prod_full;
  logic [pob_pkg::REG_W-1:0]  dx_lo_r;
  logic [pob_pkg::IDX_W-1:0]  idx_r, idx_nxt;

  // stage 1: place the pixel and clamp the destination size
  assign dx_nxt = {offset_x[pob_pkg::REG_W-1], offset_x} + {{EXT_W{1'b0}}, ovl_col};
  assign dy_nxt = {offset_y[pob_pkg::REG_W-1], offset_y} + {{EXT_W{1'b0}}, ovl_row};
  assign w_nxt  = ({{PAD_W{1'b0}}, dest_width} > 32'(MAX_DIM)) ?
                  pob_pkg::REG_W'(MAX_DIM) : dest_width;
  assign h_nxt  = ({{PAD_W{1'b0}}, dest_height} > 32'(MAX_DIM)) ?
                  pob_pkg::REG_W'(MAX_DIM) : dest_height;

  // stage 2: clip and row times width
  assign inside_nxt = !dx_r[pob_pkg::POS_W-1] && !dy_r[pob_pkg::POS_W-1] &&
                      (dx_r[pob_pkg::REG_W-1:0] < w_r) &&
                      (dy_r[pob_pkg::REG_W-1:0] < h_r);
  assign prod_full  = dy_r[pob_pkg::REG_W-1:0] * w_r;

  // stage 3: add the column, zero index outside
  assign idx_nxt = inside_r ?
                   (prod_r + {{(pob_pkg::IDX_W-pob_pkg::REG_W){1'b0}}, dx_lo_r}) :
                   '0;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
    end
    if (adv.s2) begin
      inside_r <= inside_nxt;
      prod_r   <= prod_full[pob_pkg::IDX_W-1:0];
      dx_lo_r  <= dx_r[pob_pkg::REG_W-1:0];
    end
    if (adv.s3) begin
      idx_r <= idx_nxt;
    end
  end

  assign inside_s2  = inside_r;
  assign dest_index = idx_r;

endmodule

// ===== design/pob_blend.sv =====
`timescale 1ns / 1ps

module pob_blend (
  input  logic                         clk,
  input  pob_pkg::pob_adv_t            adv,
  input  pob_pkg::pix_t                src,
  input  pob_pkg::pix_t                bg,
  input  logic                         inside_s2,
  output pob_pkg::pix_t                res,
  output logic                         write_enable
);

  localparam int AL = pob_pkg::LANES - 1;
  localparam int W2 = 2 * pob_pkg::BYTE_W;

  pob_pkg::pix_t                        src1_r, bg1_r, src2_r, bg2_r;
  logic [pob_pkg::BYTE_W-1:0]           inv1_r;
  logic                                 nz1_r, nz2_r;
  logic [pob_pkg::LANES-1:0][W2-1:0]    t_r, t_nxt;
  logic [pob_pkg::LANES-1:0][W2:0]      q_sum;
  pob_pkg::pix_t                        mix, res_r, res_nxt;
  logic                                 we_r, we_nxt;

  // stage 2: destination byte times inverse alpha, plus rounding bias
  always_comb begin
    for (int k = 0; k < pob_pkg::LANES; k++) begin
      t_nxt[k] = bg1_r[k] * inv1_r + pob_pkg::ROUND_BIAS;
    end
  end

  // stage 3: exact floor divide by 255 (t stays below 255*256), then add source
  always_comb begin
    for (int k = 0; k < pob_pkg::LANES; k++) begin
      q_sum[k] = {1'b0, t_r[k]} + (W2+1)'(1) +
                 {{(pob_pkg::BYTE_W+1){1'b0}}, t_r[k][W2-1:pob_pkg::BYTE_W]};
      mix[k]   = src2_r[k] + q_sum[k][W2-1:pob_pkg::BYTE_W];
    end
  end

  assign we_nxt  = inside_s2 && nz2_r;
  assign res_nxt = we_nxt ? mix : bg2_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      src1_r <= src;
      bg1_r  <= bg;
      inv1_r <= ~src[AL];
      nz1_r  <= |src[AL];
    end
    if (adv.s2) begin
      src2_r <= src1_r;
      bg2_r  <= bg1_r;
      nz2_r  <= nz1_r;
      t_r    <= t_nxt;
    end
    if (adv.s3) begin
      res_r <= res_nxt;
      we_r  <= we_nxt;
    end
  end

  assign res          = res_r;
  assign write_enable = we_r;

endmodule

// ===== design/premultiplied_alpha_over_blend.sv =====
`timescale 1ns / 1ps
// Pipeline: three register stages (s1, s2, s3); an accepted transaction is loaded into s1,
// then moves to s2 and s3, and the s3 output register presents it until it is taken.
// Throughput: one pixel per clock while the receiver takes results; each of the three
// stages holds its own valid bit, so bubbles collapse and the input stays ready while a
// result waits on the output, until all three stages hold a transaction.
// Reset: synchronous active-low rst_n clears all stage valid bits and the four
// configuration registers (offsets and sizes read as zero); pixel data is not reset.

module premultiplied_alpha_over_blend #(
  parameter int MAX_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  pob_in_if.sink    in_pix,
  pob_out_if.source out_pix,
  pob_cfg_if.sink   cfg_wr
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken every cycle; software must change
  // them only while the pipeline is empty; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  logic [pob_pkg::REG_W-1:0] offset_x_r, offset_y_r, dest_width_r, dest_height_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      dest_width_r  <= '0;
      dest_height_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        pob_pkg::CFG_OFFSET_X:    offset_x_r    <= cfg_wr.data;
        pob_pkg::CFG_OFFSET_Y:    offset_y_r    <= cfg_wr.data;
        pob_pkg::CFG_DEST_WIDTH:  dest_width_r  <= cfg_wr.data;
        pob_pkg::CFG_DEST_HEIGHT: dest_height_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or the stage after it
  // moves on; the last stage is the output register.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  pob_pkg::pob_adv_t adv;

  assign rdy3 = !v3_r || out_pix.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: geometry (place, clip, linear index) runs beside the per-byte
  // blend; the clip decision from geometry stage 2 steers the final select.
  // ---------------------------------------------------------------------------
  logic                       inside_s2;
  logic [pob_pkg::IDX_W-1:0]  dest_index;
  pob_pkg::pix_t              src, bg, res;
  logic                       write_enable;

  assign src = {in_pix.src_alpha, in_pix.src_c2, in_pix.src_c1, in_pix.src_c0};
  assign bg  = {in_pix.bg_alpha, in_pix.bg_c2, in_pix.bg_c1, in_pix.bg_c0};

  pob_geom #(
    .MAX_DIM (MAX_DIM)
  ) u_geom (
    .clk         (clk),
    .adv         (adv),
    .offset_x    (offset_x_r),
    .offset_y    (offset_y_r),
    .dest_width  (dest_width_r),
    .dest_height (dest_height_r),
    .ovl_col     (in_pix.ovl_col),
    .ovl_row     (in_pix.ovl_row),
    .inside_s2   (inside_s2),
    .dest_index  (dest_index)
  );

  pob_blend u_blend (
    .clk          (clk),
    .adv          (adv),
    .src          (src),
    .bg           (bg),
    .inside_s2    (inside_s2),
    .res          (res),
    .write_enable (write_enable)
  );

  // Drive the result channel from the output register.
  assign out_pix.valid        = v3_r;
  assign out_pix.out_c0       = res[0];
  assign out_pix.out_c1       = res[1];
  assign out_pix.out_c2       = res[2];
  assign out_pix.out_alpha    = res[3];
  assign out_pix.write_enable = write_enable;
  assign out_pix.dest_index   = dest_index;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> v2_r)
    else $error("stage 1 transaction lost on advance");

  a_written_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && out_pix.write_enable) |-> (out_pix.out_alpha != '0))
    else $error("written pixel has zero alpha");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/pob_blend_checker.sv =====
`timescale 1ns / 1ps

module pob_blend_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic clk,
  input  logic rst_n,
  pob_in_if    in_mon,
  pob_out_if   out_mon,
  pob_cfg_if   cfg_mon,
  output int   err_count,
  output int   in_flight
);

  localparam logic [pob_pkg::BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [pob_pkg::BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam int                         FULL_SCALE   = 255;

  typedef struct packed {
    pob_pkg::pix_t             lanes;
    logic                      wr_en;
    logic [pob_pkg::IDX_W-1:0] index;
  } blend_res_t;

  logic signed [pob_pkg::REG_W-1:0] org_x, org_y;
  logic        [pob_pkg::REG_W-1:0] span_w, span_h;
  blend_res_t                       awaited_px[$];
  string                            lane_name[pob_pkg::LANES] =
                                      '{"out_c0", "out_c1", "out_c2", "out_alpha"};

  // Porter-Duff over on one premultiplied pixel, clipped to the destination.
  function automatic blend_res_t blend_pixel(input logic [pob_pkg::COORD_W-1:0] col,
                                             input logic [pob_pkg::COORD_W-1:0] row,
                                             input pob_pkg::pix_t src,
                                             input pob_pkg::pix_t bg);
    blend_res_t r;
    int w, h, dx, dy, inv, sum;
    r.lanes = bg;
    r.wr_en = 1'b0;
    r.index = '0;
    w  = (int'(span_w) > MAX_DIM) ? MAX_DIM : int'(span_w);
    h  = (int'(span_h) > MAX_DIM) ? MAX_DIM : int'(span_h);
    dx = int'(org_x) + int'(col);
    dy = int'(org_y) + int'(row);
    if (dx >= 0 && dy >= 0 && dx < w && dy < h) begin
      r.index = pob_pkg::IDX_W'(dy * w + dx);
      if (src[pob_pkg::LANES-1] == ALPHA_OPAQUE) begin
        r.lanes = src;
        r.wr_en = 1'b1;
      end else if (src[pob_pkg::LANES-1] != ALPHA_CLEAR) begin
        inv = FULL_SCALE - int'(src[pob_pkg::LANES-1]);
        for (int l = 0; l < pob_pkg::LANES; l++) begin
          sum = int'(src[l]) +
                (int'(bg[l]) * inv + int'(pob_pkg::ROUND_BIAS)) / FULL_SCALE;
          r.lanes[l] = sum[pob_pkg::BYTE_W-1:0];
        end
        r.wr_en = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    err_count++;
    $display("%0t: mismatch on %s expected %0h actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    blend_res_t want, got;
    if (!rst_n) begin
      org_x  = '0;
      org_y  = '0;
      span_w = '0;
      span_h = '0;
      awaited_px.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (pob_pkg::cfg_reg_t'(cfg_mon.index))
          pob_pkg::CFG_OFFSET_X:    org_x  = cfg_mon.data;
          pob_pkg::CFG_OFFSET_Y:    org_y  = cfg_mon.data;
          pob_pkg::CFG_DEST_WIDTH:  span_w = cfg_mon.data;
          pob_pkg::CFG_DEST_HEIGHT: span_h = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        awaited_px.push_back(blend_pixel(in_mon.ovl_col, in_mon.ovl_row,
          {in_mon.src_alpha, in_mon.src_c2, in_mon.src_c1, in_mon.src_c0},
          {in_mon.bg_alpha, in_mon.bg_c2, in_mon.bg_c1, in_mon.bg_c0}));
      if (out_mon.valid && out_mon.ready) begin
        got.lanes = {out_mon.out_alpha, out_mon.out_c2, out_mon.out_c1, out_mon.out_c0};
        got.wr_en = out_mon.write_enable;
        got.index = out_mon.dest_index;
        if (awaited_px.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result expected none actual %0h", $time, got);
        end else begin
          want = awaited_px.pop_front();
          for (int l = 0; l < pob_pkg::LANES; l++)
            if (got.lanes[l] !== want.lanes[l])
              report(lane_name[l], want.lanes[l], got.lanes[l]);
          if (got.wr_en !== want.wr_en)
            report("write_enable", want.wr_en, got.wr_en);
          if (got.index !== want.index)
            report("dest_index", want.index, got.index);
        end
      end
    end
    in_flight = awaited_px.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM_CAP      = 4096;
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off for the backpressure phase
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE       = 6;     // pipeline is three deep; leave some margin
  localparam int FIXED_PHASES = 8;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 52;
  localparam int COORD_MAX    = (1 << pob_pkg::COORD_W) - 1;

  typedef struct {
    logic [pob_pkg::COORD_W-1:0] col;
    logic [pob_pkg::COORD_W-1:0] row;
    pob_pkg::pix_t               src;
    pob_pkg::pix_t               bg;
  } pix_item_t;

  logic clk;
  logic rst_n;
  int   err_count;
  int   in_flight;
  int   stall_cycles = 0;
  int   hold_req = 0;     // count of long hold-off requests to the receiver
  int   geo_ox, geo_oy, geo_w, geo_h;

  pob_in_if  in_pix();
  pob_out_if out_pix();
  pob_cfg_if cfg_wr();

  premultiplied_alpha_over_blend #(.MAX_DIM(DIM_CAP)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .cfg_wr  (cfg_wr)
  );

  pob_blend_checker #(.MAX_DIM(DIM_CAP)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_pix),
    .out_mon   (out_pix),
    .cfg_mon   (cfg_wr),
    .err_count (err_count),
    .in_flight (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Aim a coordinate at the clip edges or inside the span; fall back to any
  // overlay coordinate when the target cannot be reached from this origin.
  function automatic logic [pob_pkg::COORD_W-1:0] pick_coord(input int span, input int org);
    int t, sel;
    sel = $urandom_range(0, 9);
    if (sel < 2 || span == 0) return pob_pkg::COORD_W'($urandom_range(0, COORD_MAX));
    case (sel)
      2:       t = -1;
      3:       t = span;
      4:       t = span - 1;
      default: t = $urandom_range(0, span - 1);
    endcase
    t = t - org;
    if (t < 0 || t > COORD_MAX) return pob_pkg::COORD_W'($urandom_range(0, COORD_MAX));
    return pob_pkg::COORD_W'(t);
  endfunction

  function automatic pix_item_t rand_pixel();
    pix_item_t it;
    int sel;
    bit premult;
    it.col = pick_coord((geo_w > DIM_CAP) ? DIM_CAP : geo_w, geo_ox);
    it.row = pick_coord((geo_h > DIM_CAP) ? DIM_CAP : geo_h, geo_oy);
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2: it.src[pob_pkg::LANES-1] = 8'h00;
      3, 4, 5: it.src[pob_pkg::LANES-1] = 8'hFF;
      6:       it.src[pob_pkg::LANES-1] = 8'h01;
      7:       it.src[pob_pkg::LANES-1] = 8'hFE;
      default: it.src[pob_pkg::LANES-1] = pob_pkg::BYTE_W'($urandom);
    endcase
    // Well-formed premultiplied colour most of the time; the rest is random and may wrap.
    premult = ($urandom_range(0, 3) != 0);
    for (int l = 0; l < pob_pkg::LANES - 1; l++)
      it.src[l] = premult ?
                  pob_pkg::BYTE_W'($urandom_range(0, it.src[pob_pkg::LANES-1])) :
                  pob_pkg::BYTE_W'($urandom);
    it.bg = $urandom;
    return it;
  endfunction

  function automatic pix_item_t px(input int col, input int row, input pob_pkg::pix_t src,
                                   input pob_pkg::pix_t bg);
    pix_item_t it;
    it.col = pob_pkg::COORD_W'(col);
    it.row = pob_pkg::COORD_W'(row);
    it.src = src;
    it.bg  = bg;
    return it;
  endfunction

  // Drive one register write and hold it until the transaction completes.
  task automatic write_reg(input pob_pkg::cfg_reg_t r, input logic [pob_pkg::REG_W-1:0] v);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= r;
    cfg_wr.data  <= v;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic set_geometry(input int ox, input int oy, input int w, input int h);
    geo_ox = ox;
    geo_oy = oy;
    geo_w  = w;
    geo_h  = h;
    write_reg(pob_pkg::CFG_OFFSET_X,    pob_pkg::REG_W'(ox));
    write_reg(pob_pkg::CFG_OFFSET_Y,    pob_pkg::REG_W'(oy));
    write_reg(pob_pkg::CFG_DEST_WIDTH,  pob_pkg::REG_W'(w));
    write_reg(pob_pkg::CFG_DEST_HEIGHT, pob_pkg::REG_W'(h));
  endtask

  // Present one pixel; valid is left high so a following pixel can go back-to-back.
  task automatic send_pixel(input pix_item_t it);
    @(negedge clk);
    in_pix.valid     <= 1'b1;
    in_pix.ovl_col   <= it.col;
    in_pix.ovl_row   <= it.row;
    in_pix.src_c0    <= it.src[0];
    in_pix.src_c1    <= it.src[1];
    in_pix.src_c2    <= it.src[2];
    in_pix.src_alpha <= it.src[3];
    in_pix.bg_c0     <= it.bg[0];
    in_pix.bg_c1     <= it.bg[1];
    in_pix.bg_c2     <= it.bg[2];
    in_pix.bg_alpha  <= it.bg[3];
    do @(posedge clk); while (!in_pix.ready);
  endtask

  task automatic pause_in(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_pix.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every predicted pixel has come back.
  task automatic drain_results();
    @(negedge clk);
    in_pix.valid <= 1'b0;
    wait (in_flight == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: runs of ready with random gaps, plus one long hold-off on request.
  initial begin
    int hold_left, low_left, high_left, holds_seen;
    hold_left  = 0;
    low_left   = 0;
    high_left  = 0;
    holds_seen = 0;
    out_pix.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_pix.ready <= 1'b0;
        hold_left--;
      end else if (low_left > 0) begin
        out_pix.ready <= 1'b0;
        low_left--;
      end else begin
        out_pix.ready <= 1'b1;
        if (high_left > 0) begin
          high_left--;
        end else begin
          high_left = $urandom_range(0, 25);
          low_left  = gap_len();
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int ox_tab[FIXED_PHASES] = '{0, -5, 4095, -4096, 100, 0, 3, -100};
    int oy_tab[FIXED_PHASES] = '{0, -3, 4095, 0, 200, 0, -1, 7};
    int w_tab[FIXED_PHASES]  = '{16, 37, 4096, 8191, 4096, 0, 1, 300};
    int h_tab[FIXED_PHASES]  = '{16, 9, 4096, 5000, 4096, 50, 1, 4097};
    bit bursty;

    geo_ox            = 0;
    geo_oy            = 0;
    geo_w             = 0;
    geo_h             = 0;
    in_pix.valid      = 1'b0;
    in_pix.ovl_col    = '0;
    in_pix.ovl_row    = '0;
    in_pix.src_c0     = '0;
    in_pix.src_c1     = '0;
    in_pix.src_c2     = '0;
    in_pix.src_alpha  = '0;
    in_pix.bg_c0      = '0;
    in_pix.bg_c1      = '0;
    in_pix.bg_c2      = '0;
    in_pix.bg_alpha   = '0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = pob_pkg::CFG_OFFSET_X;
    cfg_wr.data       = '0;
    rst_n             = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry is 0x0: nothing can land inside.
    send_pixel(px(0, 0, 32'hFF102030, 32'h40506070));
    send_pixel(px(4095, 4095, 32'h80404040, 32'hFFFFFFFF));
    send_pixel(px(0, 0, 32'h00000000, 32'h01020304));
    drain_results();

    // Small destination at the origin: every alpha class and the clip edges.
    set_geometry(0, 0, 16, 8);
    send_pixel(px(0, 0, 32'h00AABBCC, 32'h11223344));    // transparent, index 0
    send_pixel(px(5, 3, 32'h00FFFFFF, 32'h55667788));    // transparent, mid index
    send_pixel(px(15, 7, 32'hFF123456, 32'hFFFFFFFF));   // opaque at last pixel
    send_pixel(px(0, 0, 32'hFFFFFFFF, 32'h00000000));
    send_pixel(px(1, 0, 32'h01000000, 32'hFFFFFFFF));    // faintest coverage
    send_pixel(px(2, 0, 32'hFEFEFEFE, 32'hFFFFFFFF));    // near-opaque
    send_pixel(px(3, 1, 32'h80808080, 32'h80808080));
    send_pixel(px(4, 1, 32'h01FFFFFF, 32'hFFFFFFFF));    // colour above alpha wraps
    send_pixel(px(6, 2, 32'h64C8C8C8, 32'hFFFFFFFF));
    send_pixel(px(16, 0, 32'hFF010203, 32'h0A0B0C0D));   // one past the right edge
    send_pixel(px(0, 8, 32'hFF010203, 32'h0A0B0C0D));    // one past the bottom edge
    send_pixel(px(4095, 4095, 32'h7F7F7F7F, 32'h3C3C3C3C));
    send_pixel(px(7, 4, 32'h00000000, 32'h00000000));
    send_pixel(px(8, 5, 32'hFFFFFFFF, 32'hFFFFFFFF));
    drain_results();

    // Negative origin with oversized size registers clamped to the cap.
    set_geometry(-1, -1, 8191, 8191);
    send_pixel(px(0, 0, 32'hFF445566, 32'h00000000));
    send_pixel(px(1, 1, 32'hC0A0B0C0, 32'h20304050));
    send_pixel(px(4095, 4095, 32'h40302010, 32'hF0E0D0C0));
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        set_geometry(ox_tab[p], oy_tab[p], w_tab[p], h_tab[p]);
      end else if (p == NUM_PHASES - 1) begin
        set_geometry(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                     $urandom_range(0, 8191), $urandom_range(0, 8191));
      end else begin
        set_geometry(int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32,
                     $urandom_range(1, 80), $urandom_range(1, 80));
      end
      bursty = ($urandom_range(0, 3) == 0);

      if (p == 1) begin
        // Backpressure: hold off the receiver and keep offering pixels so the
        // pipeline fills and the input stalls.
        hold_req++;
        repeat (24) send_pixel(rand_pixel());
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through, stop sending until the pipeline is empty.
        if (k == PHASE_ITEMS / 2) drain_results();
        send_pixel(rand_pixel());
        if (!bursty) pause_in(gap_len());
      end
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && in_flight == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
